@@ sv/conveyor_block_sorter_sequencer_defines.svh @@
// assertion macros shared by the sorter sequencer checker
// no dependencies; included by files that assert
`ifndef CONVEYOR_BLOCK_SORTER_SEQUENCER_DEFINES_SVH
`define CONVEYOR_BLOCK_SORTER_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CBSS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CBSS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cbss_pkg.sv @@
// types, constants and helper functions of the sorter sequencer
// no dependencies; used by the top level and its checker
package cbss_pkg;

  localparam int SMALL_SLOTS = 5;
  localparam int LARGE_SLOTS = 3;
  localparam int TOTAL_WIDTH = 16;

  localparam int DELAY_W     = 16;
  localparam int OUT_TOTAL_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int SMALL_PTR_W = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
  localparam int LARGE_PTR_W = (LARGE_SLOTS > 1) ? $clog2(LARGE_SLOTS) : 1;
  localparam int BUMP_W      = $clog2(LARGE_SLOTS + 1);
  localparam int NUM_TOTALS  = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_DELAY0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_DELAY1  = 3'd4;

  // register reset values, in ticks
  localparam logic [DELAY_W-1:0] RST_SAMPLE_PERIOD = 16'd30;
  localparam logic [DELAY_W-1:0] RST_CLOSE_DELAY   = 16'd250;
  localparam logic [DELAY_W-1:0] RST_OPEN_DELAY    = 16'd420;
  localparam logic [DELAY_W-1:0] RST_COUNT_DELAY0  = 16'd460;
  localparam logic [DELAY_W-1:0] RST_COUNT_DELAY1  = 16'd480;

  // request types
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // size sensor codes
  localparam logic [1:0] SIZE_NONE  = 2'd0;
  localparam logic [1:0] SIZE_FRONT = 2'd1;
  localparam logic [1:0] SIZE_LARGE = 2'd3;

  // detection event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_SMALL_B0 = 3'd1;
  localparam logic [2:0] EV_LARGE_B0 = 3'd2;
  localparam logic [2:0] EV_SMALL_B1 = 3'd3;
  localparam logic [2:0] EV_LARGE_B1 = 3'd4;

  // total slots
  localparam int TOT_SMALL_B0 = 0;
  localparam int TOT_COLL_B0  = 4;

  typedef struct packed {
    logic       req_type;
    logic [1:0] size_code_belt_zero;
    logic [1:0] size_code_belt_one;
    logic       count_seen_belt_zero;
    logic       count_seen_belt_one;
  } item_t;

  typedef struct packed {
    logic [1:0]             gate_drive;
    logic [OUT_TOTAL_W-1:0] small_total_belt_zero;
    logic [OUT_TOTAL_W-1:0] large_total_belt_zero;
    logic [OUT_TOTAL_W-1:0] small_total_belt_one;
    logic [OUT_TOTAL_W-1:0] large_total_belt_one;
    logic [OUT_TOTAL_W-1:0] collected_belt_zero;
    logic [OUT_TOTAL_W-1:0] collected_belt_one;
    logic [2:0]             detect_event;
  } result_t;

  // a zero delay counts as one tick
  function automatic logic [DELAY_W-1:0] at_least_one(input logic [DELAY_W-1:0] d);
    return (d == '0) ? DELAY_W'(1) : d;
  endfunction

  // saturating add of a small count
  function automatic logic [TOTAL_WIDTH-1:0] sat_add(input logic [TOTAL_WIDTH-1:0] v,
                                                     input logic [BUMP_W-1:0] n);
    logic [TOTAL_WIDTH:0] s;
    s = {1'b0, v} + (TOTAL_WIDTH+1)'(n);
    return s[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : s[TOTAL_WIDTH-1:0];
  endfunction

endpackage

@@ sv/conveyor_block_sorter_sequencer.sv @@
// two-belt block sorter sequencer, one tick per tick item, none per clear item
// depends on cbss_pkg
//
// channel   dir  handshake              payload
// item      in   item_valid/item_stall  cbss_pkg::item_t
// result    out  result_valid/result_stall cbss_pkg::result_t
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// one item per cycle while item_stall is low; its result shows in the output register in the next cycle
// all countdown slots, the divider and the totals update together when the item is accepted
// the item side stalls only in reset or while a result waits and the output side stalls
// rst is synchronous: clears all sequencing state and result_valid, loads register defaults, stalls items
module conveyor_block_sorter_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  cbss_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output cbss_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [cbss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbss_pkg::DELAY_W-1:0]        cfg_data
);
  import cbss_pkg::*;

  // configuration registers
  logic [DELAY_W-1:0] sample_period;
  logic [DELAY_W-1:0] close_delay;
  logic [DELAY_W-1:0] open_delay;
  logic [DELAY_W-1:0] count_delay [2];

  // sequencing state
  logic [1:0]             prev_code       [2];
  logic [1:0]             prev_code_next  [2];
  logic [DELAY_W-1:0]     divider;
  logic [DELAY_W-1:0]     divider_next;
  logic [DELAY_W-1:0]     close_cnt       [2][SMALL_SLOTS];
  logic [DELAY_W-1:0]     close_cnt_next  [2][SMALL_SLOTS];
  logic [DELAY_W-1:0]     open_cnt        [2][SMALL_SLOTS];
  logic [DELAY_W-1:0]     open_cnt_next   [2][SMALL_SLOTS];
  logic [DELAY_W-1:0]     check_cnt       [2][LARGE_SLOTS];
  logic [DELAY_W-1:0]     check_cnt_next  [2][LARGE_SLOTS];
  logic [SMALL_PTR_W-1:0] small_ptr       [2];
  logic [SMALL_PTR_W-1:0] small_ptr_next  [2];
  logic [LARGE_PTR_W-1:0] large_ptr       [2];
  logic [LARGE_PTR_W-1:0] large_ptr_next  [2];
  logic [1:0]             gate_closed;
  logic [1:0]             gate_closed_next;
  logic [1:0]             gate_drive;
  logic [1:0]             gate_drive_next;
  logic [TOTAL_WIDTH-1:0] totals          [NUM_TOTALS];
  logic [TOTAL_WIDTH-1:0] totals_next     [NUM_TOTALS];

  logic                   accept;
  logic [1:0]             close_fire;
  logic [1:0]             open_fire;
  logic [BUMP_W-1:0]      check_fires     [2];
  logic [1:0]             seen;
  logic [1:0]             code            [2];
  logic [2:0]             belt_ev         [2];
  logic [2:0]             ev;
  logic [DELAY_W:0]       divider_inc;
  result_t                result_next;

  // output register parts the two sides; a waiting result is held
  assign item_stall = rst | (result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;

  assign code[0] = item.size_code_belt_zero;
  assign code[1] = item.size_code_belt_one;
  assign seen    = {item.count_seen_belt_one, item.count_seen_belt_zero};

  always_comb begin
    prev_code_next   = prev_code;
    divider_next     = divider;
    close_cnt_next   = close_cnt;
    open_cnt_next    = open_cnt;
    check_cnt_next   = check_cnt;
    small_ptr_next   = small_ptr;
    large_ptr_next   = large_ptr;
    gate_closed_next = gate_closed;
    gate_drive_next  = gate_drive;
    totals_next      = totals;
    close_fire       = '0;
    open_fire        = '0;
    check_fires[0]   = '0;
    check_fires[1]   = '0;
    belt_ev[0]       = EV_NONE;
    belt_ev[1]       = EV_NONE;
    ev               = EV_NONE;
    divider_inc      = {1'b0, divider} + (DELAY_W+1)'(1);

    if (item.req_type == REQ_CLEAR) begin
      // clear request: totals only, no tick passes
      for (int k = 0; k < NUM_TOTALS; k++) begin
        totals_next[k] = '0;
      end
    end else begin
      // every running countdown steps down; reaching zero fires
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < SMALL_SLOTS; i++) begin
          if (close_cnt[b][i] != '0) begin
            close_cnt_next[b][i] = close_cnt[b][i] - DELAY_W'(1);
            if (close_cnt[b][i] == DELAY_W'(1)) close_fire[b] = 1'b1;
          end
          if (open_cnt[b][i] != '0) begin
            open_cnt_next[b][i] = open_cnt[b][i] - DELAY_W'(1);
            if (open_cnt[b][i] == DELAY_W'(1)) open_fire[b] = 1'b1;
          end
        end
        for (int i = 0; i < LARGE_SLOTS; i++) begin
          if (check_cnt[b][i] != '0) begin
            check_cnt_next[b][i] = check_cnt[b][i] - DELAY_W'(1);
            if (check_cnt[b][i] == DELAY_W'(1)) check_fires[b] = check_fires[b] + BUMP_W'(1);
          end
        end
        // a close and an open in one tick leave the gate open
        if (close_fire[b]) gate_closed_next[b] = 1'b1;
        if (open_fire[b])  gate_closed_next[b] = 1'b0;
        // each expiring check counts once if the sensor shows a block
        if (seen[b]) begin
          totals_next[TOT_COLL_B0 + b] = sat_add(totals[TOT_COLL_B0 + b], check_fires[b]);
        end
      end
      if ((close_fire | open_fire) != 2'b00) gate_drive_next = gate_closed_next;

      // sample divider; a period lowered below the divider samples now
      if (divider_inc >= {1'b0, at_least_one(sample_period)}) begin
        divider_next = '0;
        for (int b = 0; b < 2; b++) begin
          prev_code_next[b] = code[b];
          if (prev_code[b] == SIZE_FRONT) begin
            if (code[b] == SIZE_NONE) begin
              // small block: arm the next close/open slot pair, restarting it if busy
              for (int i = 0; i < SMALL_SLOTS; i++) begin
                if (small_ptr[b] == SMALL_PTR_W'(i)) begin
                  close_cnt_next[b][i] = at_least_one(close_delay);
                  open_cnt_next[b][i]  = at_least_one(open_delay);
                end
              end
              small_ptr_next[b] = (small_ptr[b] == SMALL_PTR_W'(SMALL_SLOTS - 1)) ?
                                  '0 : small_ptr[b] + SMALL_PTR_W'(1);
              totals_next[TOT_SMALL_B0 + 2*b] =
                sat_add(totals[TOT_SMALL_B0 + 2*b], BUMP_W'(1));
              belt_ev[b] = (b == 0) ? EV_SMALL_B0 : EV_SMALL_B1;
            end else if (code[b] == SIZE_LARGE) begin
              // large block: both gates open now, count check later
              for (int i = 0; i < LARGE_SLOTS; i++) begin
                if (large_ptr[b] == LARGE_PTR_W'(i)) begin
                  check_cnt_next[b][i] = at_least_one(count_delay[b]);
                end
              end
              large_ptr_next[b] = (large_ptr[b] == LARGE_PTR_W'(LARGE_SLOTS - 1)) ?
                                  '0 : large_ptr[b] + LARGE_PTR_W'(1);
              gate_drive_next = 2'b00;
              totals_next[TOT_SMALL_B0 + 2*b + 1] =
                sat_add(totals[TOT_SMALL_B0 + 2*b + 1], BUMP_W'(1));
              belt_ev[b] = (b == 0) ? EV_LARGE_B0 : EV_LARGE_B1;
            end
          end
        end
        // belt zero event is reported when both belts detect
        ev = (belt_ev[0] != EV_NONE) ? belt_ev[0] : belt_ev[1];
      end else begin
        divider_next = divider_inc[DELAY_W-1:0];
      end
    end
  end

  always_comb begin
    result_next.gate_drive            = gate_drive_next;
    result_next.small_total_belt_zero = OUT_TOTAL_W'(totals_next[0]);
    result_next.large_total_belt_zero = OUT_TOTAL_W'(totals_next[1]);
    result_next.small_total_belt_one  = OUT_TOTAL_W'(totals_next[2]);
    result_next.large_total_belt_one  = OUT_TOTAL_W'(totals_next[3]);
    result_next.collected_belt_zero   = OUT_TOTAL_W'(totals_next[4]);
    result_next.collected_belt_one    = OUT_TOTAL_W'(totals_next[5]);
    result_next.detect_event          = ev;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period  <= RST_SAMPLE_PERIOD;
      close_delay    <= RST_CLOSE_DELAY;
      open_delay     <= RST_OPEN_DELAY;
      count_delay[0] <= RST_COUNT_DELAY0;
      count_delay[1] <= RST_COUNT_DELAY1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period  <= cfg_data;
        REG_CLOSE_DELAY:   close_delay    <= cfg_data;
        REG_OPEN_DELAY:    open_delay     <= cfg_data;
        REG_COUNT_DELAY0:  count_delay[0] <= cfg_data;
        REG_COUNT_DELAY1:  count_delay[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      divider     <= '0;
      gate_closed <= '0;
      gate_drive  <= '0;
      for (int b = 0; b < 2; b++) begin
        prev_code[b] <= '0;
        small_ptr[b] <= '0;
        large_ptr[b] <= '0;
        for (int i = 0; i < SMALL_SLOTS; i++) begin
          close_cnt[b][i] <= '0;
          open_cnt[b][i]  <= '0;
        end
        for (int i = 0; i < LARGE_SLOTS; i++) begin
          check_cnt[b][i] <= '0;
        end
      end
      for (int k = 0; k < NUM_TOTALS; k++) begin
        totals[k] <= '0;
      end
    end else if (accept) begin
      divider     <= divider_next;
      gate_closed <= gate_closed_next;
      gate_drive  <= gate_drive_next;
      prev_code   <= prev_code_next;
      small_ptr   <= small_ptr_next;
      large_ptr   <= large_ptr_next;
      close_cnt   <= close_cnt_next;
      open_cnt    <= open_cnt_next;
      check_cnt   <= check_cnt_next;
      totals      <= totals_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

@@ sv/cbss_checker.sv @@
// port-level checks of the sorter sequencer, bound to its top level
// depends on cbss_pkg and conveyor_block_sorter_sequencer_defines.svh
`include "conveyor_block_sorter_sequencer_defines.svh"

module cbss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_stall,
  input cbss_pkg::item_t                item,
  input logic                           result_valid,
  input logic                           result_stall,
  input cbss_pkg::result_t              result
);
  import cbss_pkg::*;

  logic result_held;
  logic clear_taken;
  logic clear_shown;
  logic large_shown;

  assign result_held = result_valid && result_stall;
  assign clear_taken = item_valid && !item_stall && (item.req_type == REQ_CLEAR);
  assign clear_shown = result_valid && (result.detect_event == EV_NONE) &&
                       (result.small_total_belt_zero == '0) &&
                       (result.large_total_belt_zero == '0) &&
                       (result.small_total_belt_one == '0) &&
                       (result.large_total_belt_one == '0) &&
                       (result.collected_belt_zero == '0) &&
                       (result.collected_belt_one == '0);
  assign large_shown = result_valid && ((result.detect_event == EV_LARGE_B0) ||
                                        (result.detect_event == EV_LARGE_B1));

  // a stalled result holds
  `CBSS_ASSERT_NEXT(a_result_hold, clk, rst, result_held, result_valid && $stable(result), "stalled result changed")

  // the item side stalls only behind a waiting result
  `CBSS_ASSERT_NOW(a_stall_cause, clk, rst, item_stall, result_held, "item stalled without a waiting result")

  // a clear request yields zero totals and no event
  `CBSS_ASSERT_NEXT(a_clear, clk, rst, clear_taken, clear_shown, "clear request left totals or an event")

  // a large detection leaves both gates open
  `CBSS_ASSERT_NOW(a_large_open, clk, rst, large_shown, result.gate_drive == 2'b00, "gate closed on large detection")

endmodule

bind conveyor_block_sorter_sequencer cbss_checker u_cbss_checker (.*);
